/* hdl/tfj_pkg.sv */
// ----------------------------------------------------------------------------
// tfj_pkg: shared definitions of the text justifier
// Sizes, the space code and the sequencer state type.
// ----------------------------------------------------------------------------
package tfj_pkg;
	localparam int MAX_WIDTH = 32;
	localparam int MAX_WORDS = 16;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [5:0] WIDTH_RESET = 6'd16;
	localparam logic [0:0] ADDR_LINE_WIDTH = 1'b0;

	typedef logic [7:0] char_t;
	typedef logic [5:0] len_t;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_COPY = 5'b00010,
		ST_LAST = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;
endpackage

/* hdl/tfj_if.sv */
// ----------------------------------------------------------------------------
// tfj_if: item channels of the text justifier
// Input character channel and output line character channel.
// ----------------------------------------------------------------------------
interface tfj_in_if;
	logic                valid;
	logic                ready;
	tfj_pkg::char_t      ch;
	logic                word_end;
	logic                text_end;
	modport source (output valid, ch, word_end, text_end, input ready);
	modport sink (input valid, ch, word_end, text_end, output ready);
endinterface

interface tfj_out_if;
	logic                valid;
	logic                ready;
	tfj_pkg::char_t      out_char;
	logic                line_end;
	logic                truncated;
	logic                last;
	modport source (output valid, out_char, line_end, truncated, last, input ready);
	modport sink (input valid, out_char, line_end, truncated, last, output ready);
endinterface

/* hdl/tfj_cfg.sv */
// ----------------------------------------------------------------------------
// tfj_cfg: configuration register port
// Holds the line width register behind an APB-style write and read port.
// ----------------------------------------------------------------------------
module tfj_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output tfj_pkg::len_t    line_width
);
	import tfj_pkg::*;

	len_t width_q;

	// Register write on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (psel && penable && pwrite && paddr[2] == ADDR_LINE_WIDTH) begin
			width_q <= pwdata[5:0];
		end
	end

	// Read back.
	assign prdata = (paddr[2] == ADDR_LINE_WIDTH) ? {26'd0, width_q} : 32'd0;
	assign pready = 1'b1;
	assign line_width = width_q;
endmodule

/* hdl/tfj_div.sv */
// ----------------------------------------------------------------------------
// tfj_div: iterative gap divider
// Splits the free spaces over the gaps by repeated subtraction.
// ----------------------------------------------------------------------------
module tfj_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [5:0]    dividend,
	input  logic [4:0]    divisor,
	output logic          done,
	output logic [5:0]    quotient,
	output logic [4:0]    remainder
);
	logic       busy_q;
	logic [5:0] rem_q;
	logic [5:0] quo_q;
	logic [4:0] dsr_q;

	assign done = busy_q && (rem_q < {1'b0, dsr_q});
	assign quotient = quo_q;
	assign remainder = rem_q[4:0];

	// One subtraction per cycle until the remainder drops below the divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			quo_q <= 6'd0;
			dsr_q <= divisor;
		end else if (busy_q && !done) begin
			rem_q <= rem_q - {1'b0, dsr_q};
			quo_q <= quo_q + 6'd1;
		end
	end
endmodule

/* hdl/text_full_justifier_unit.sv */
// An item with no word end is stored in the pending word buffer. A word end
// then has the word copied letter by letter into the line buffer, and passes
// through a last-word state when it also ends the text.
// A line is emitted as width characters, after a run of the subtract divider
// when it is fully justified. No new item is taken meanwhile.
// Reset (arst_n low, asynchronous) empties the line and sets width 16.
// ----------------------------------------------------------------------------
// text_full_justifier_unit: greedy full text justification
// Buffers words, then emits each line one character per cycle while the output is ready.
// ----------------------------------------------------------------------------
module text_full_justifier_unit (
	input  logic        clk,
	input  logic        arst_n,
	tfj_in_if.sink      in_item,
	tfj_out_if.source   out_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tfj_pkg::*;

	state_t state_q;
	len_t   line_width;
	len_t   w;

	char_t  pend_q [MAX_WIDTH];
	char_t  letters_q [MAX_WIDTH];
	len_t   wlen_q [MAX_WORDS];
	len_t   plen_q;
	logic   mark_q;
	logic [4:0] cnt_q;
	len_t   total_q;
	logic   ltr_q;

	len_t   len_q;
	logic   te_q;
	logic   just_q;
	logic   flag_q;
	len_t   cp_q;
	len_t   gbase_q;
	logic [4:0] extra_q;
	logic [4:0] k_q;
	len_t   cc_q;
	len_t   gc_q;
	len_t   idx_q;
	len_t   pos_q;

	logic   ov_q;
	char_t  oc_q;
	logic   oe_q;
	logic   ot_q;
	logic   ol_q;

	tfj_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.line_width(line_width)
	);

	// Effective width, clamped to one through MAX_WIDTH.
	always_comb begin
		if (line_width == 6'd0) w = 6'd1;
		else if (line_width > 6'(MAX_WIDTH)) w = 6'(MAX_WIDTH);
		else w = line_width;
	end

	// Input item decode.
	logic   accept, we, room, fl;
	len_t   plen_new, lenw;
	logic [6:0] need;
	assign accept = in_item.valid && in_item.ready;
	assign in_item.ready = (state_q == ST_IDLE);
	assign we = in_item.word_end || in_item.text_end;
	assign room = plen_q < w;
	assign plen_new = room ? plen_q + 6'd1 : plen_q;
	assign lenw = (plen_new > w) ? w : plen_new;
	assign need = {1'b0, total_q} + {2'b0, cnt_q} + {1'b0, lenw};
	assign fl = (cnt_q != 5'd0) && (need > {1'b0, w} || cnt_q >= 5'(MAX_WORDS));

	// Line start: gap count, fit test and the divider launch.
	logic [4:0] gaps;
	logic       fits, sl_div, sl_just, div_start, div_done;
	logic [5:0] div_q;
	logic [4:0] div_r;
	assign gaps = (cnt_q != 5'd0) ? cnt_q - 5'd1 : 5'd0;
	assign fits = ({1'b0, total_q} + {2'b0, gaps}) <= {1'b0, w};
	assign sl_just = (state_q == ST_IDLE);
	assign sl_div = sl_just && gaps != 5'd0 && fits;
	assign div_start = (accept && we && fl && sl_div) || (state_q == ST_LAST && sl_div);

	tfj_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(w - total_q),
		.divisor(gaps), .done(div_done), .quotient(div_q), .remainder(div_r)
	);

	// Word append fits the buffer.
	logic       ok_app;
	logic [6:0] app_sum;
	assign app_sum = {1'b0, total_q} + {1'b0, len_q};
	assign ok_app = app_sum <= 7'(MAX_WIDTH) && cnt_q < 5'(MAX_WORDS);

	// Character generator for the line being emitted.
	logic   load, wdone, lend;
	char_t  gen_c;
	len_t   nk;
	len_t   cur_len;
	logic [6:0] cp_idx;
	assign load = (state_q == ST_EMIT) && (!ov_q || out_item.ready);
	assign cur_len = wlen_q[k_q[3:0]];
	assign wdone = (cc_q + 6'd1) == cur_len;
	assign nk = gbase_q + ((k_q < extra_q) ? 6'd1 : 6'd0);
	assign lend = (pos_q + 6'd1) == w;
	assign cp_idx = {1'b0, total_q} + {1'b0, cp_q};
	always_comb begin
		if (gc_q != 6'd0) gen_c = SPACE_CHAR;
		else if (k_q < cnt_q) gen_c = (idx_q < 6'(MAX_WIDTH)) ? letters_q[idx_q[4:0]] : SPACE_CHAR;
		else gen_c = SPACE_CHAR;
	end

	// Sequencer and line control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			plen_q <= 6'd0;
			mark_q <= 1'b0;
			cnt_q <= 5'd0;
			total_q <= 6'd0;
			ltr_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && out_item.ready && !load) ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!we) begin
							plen_q <= plen_new;
							mark_q <= mark_q | !room;
						end else begin
							plen_q <= 6'd0;
							mark_q <= mark_q | !room | (plen_new > w);
							if (fl) begin
								state_q <= sl_div ? ST_DIV : ST_EMIT;
							end else begin
								state_q <= ST_COPY;
							end
						end
					end
				end
				ST_COPY: begin
					if (cp_q == len_q) begin
						if (ok_app) begin
							cnt_q <= cnt_q + 5'd1;
							total_q <= app_sum[5:0];
						end
						ltr_q <= ltr_q | mark_q;
						mark_q <= 1'b0;
						state_q <= te_q ? ST_LAST : ST_IDLE;
					end
				end
				ST_LAST: begin
					state_q <= sl_div ? ST_DIV : ST_EMIT;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						ov_q <= 1'b1;
						if (lend) begin
							cnt_q <= 5'd0;
							total_q <= 6'd0;
							ltr_q <= 1'b0;
							state_q <= just_q ? ST_COPY : ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept && room) pend_q[plen_q[4:0]] <= in_item.ch;
		if (accept && we) begin
			len_q <= lenw;
			te_q <= in_item.text_end;
			cp_q <= 6'd0;
		end
		if ((accept && we && fl) || state_q == ST_LAST) begin
			just_q <= sl_just;
			flag_q <= ltr_q | !fits;
			k_q <= 5'd0;
			cc_q <= 6'd0;
			gc_q <= 6'd0;
			idx_q <= 6'd0;
			pos_q <= 6'd0;
			if (!sl_div) begin
				gbase_q <= 6'd1;
				extra_q <= 5'd0;
			end
		end
		if (state_q == ST_DIV && div_done) begin
			gbase_q <= div_q;
			extra_q <= div_r;
		end
		if (state_q == ST_COPY && cp_q != len_q) begin
			if (ok_app) letters_q[cp_idx[4:0]] <= pend_q[cp_q[4:0]];
			cp_q <= cp_q + 6'd1;
		end
		if (state_q == ST_COPY && cp_q == len_q && ok_app) wlen_q[cnt_q[3:0]] <= len_q;
		if (state_q == ST_EMIT && lend && load) cp_q <= 6'd0;
		if (load) begin
			oc_q <= gen_c;
			oe_q <= lend;
			ot_q <= flag_q;
			ol_q <= lend && !(just_q && te_q);
			pos_q <= pos_q + 6'd1;
			if (gc_q != 6'd0) begin
				gc_q <= gc_q - 6'd1;
			end else if (k_q < cnt_q) begin
				idx_q <= idx_q + 6'd1;
				if (wdone) begin
					k_q <= k_q + 5'd1;
					cc_q <= 6'd0;
					gc_q <= ((k_q + 5'd1) < cnt_q) ? nk : 6'd0;
				end else begin
					cc_q <= cc_q + 6'd1;
				end
			end
		end
	end

	assign out_item.valid = ov_q;
	assign out_item.out_char = oc_q;
	assign out_item.line_end = oe_q;
	assign out_item.truncated = ot_q;
	assign out_item.last = ol_q;
endmodule
